// ===== rtl/core/matrix_row_sum_sorter_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix row sum sorter
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MATRIX_ROW_SUM_SORTER_DEFINES_SVH
`define MATRIX_ROW_SUM_SORTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MRSS_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("matrix_row_sum_sorter assertion failed");
`define MRSS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("matrix_row_sum_sorter assertion failed");
`else
`define MRSS_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons)
`define MRSS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

// ===== rtl/core/mrss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrss_pkg
// Shared sizes, codes and transaction types of the matrix row sum sorter.
// ----------------------------------------------------------------------------
package mrss_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int VALUE_WIDTH = 32;

  localparam int IN_VALUE_W = 32;
  localparam int OUT_W      = 32;
  localparam int SRC_ROW_W  = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 40;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLUMNS);
  localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    opcode_e                       opcode;
    logic signed [IN_VALUE_W-1:0]  element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]  out_value;
    logic [SRC_ROW_W-1:0]     source_row;
    logic                     last_in_row;
    logic                     last_in_matrix;
  } out_item_t;

  // Contents of one sorting cell.
  typedef struct packed {
    logic                    occ;
    logic signed [SUM_W-1:0] sum;
    logic [ROW_W-1:0]        row;
  } cell_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } chain_ctrl_t;

endpackage

// ===== rtl/core/mrss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrss_cell
// One cell of the sorted insertion chain: holds a row sum and its row index.
// ----------------------------------------------------------------------------
module mrss_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mrss_pkg::chain_ctrl_t        ctrl,
  input  logic signed [mrss_pkg::SUM_W-1:0] key,
  input  logic [mrss_pkg::ROW_W-1:0]   key_row,
  input  mrss_pkg::cell_t              left,
  input  logic                         left_keep,
  input  mrss_pkg::cell_t              right,
  output mrss_pkg::cell_t              q,
  output logic                         keep
);
  import mrss_pkg::*;

  logic                    occ_r, occ_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;

  // A cell keeps its entry when the new key sorts after it; equal sums stay
  // ahead of the new row, which makes the sort stable.
  assign keep = occ_r && (sum_r <= key);

  always_comb begin
    occ_nxt = occ_r;
    sum_nxt = sum_r;
    row_nxt = row_r;
    if (ctrl.clear) begin
      occ_nxt = 1'b0;
    end else if (ctrl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          occ_nxt = 1'b1;
          sum_nxt = key;
          row_nxt = key_row;
        end else begin
          occ_nxt = left.occ;
          sum_nxt = left.sum;
          row_nxt = left.row;
        end
      end
    end else if (ctrl.shift) begin
      occ_nxt = right.occ;
      sum_nxt = right.sum;
      row_nxt = right.row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    row_r <= row_nxt;
  end

  assign q = '{occ: occ_r, sum: sum_r, row: row_r};

endmodule

// ===== rtl/core/mrss_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrss_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mrss_store (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [mrss_pkg::ADDR_W-1:0]      wr_addr,
  input  logic [mrss_pkg::VALUE_WIDTH-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [mrss_pkg::ADDR_W-1:0]      rd_addr,
  output logic [mrss_pkg::VALUE_WIDTH-1:0] rd_data
);
  import mrss_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/matrix_row_sum_sorter.sv =====
`timescale 1ns / 1ps
// A read transaction's result strobes out_valid in the cycle after it is accepted.
// Throughput: one load or read per cycle while busy is low, set by the single element memory port pair.
// After the final element of each row, busy is high for one cycle while the chain inserts the sum.
// Reset (synchronous, rst_n low) empties the chain and counters; the element memory is not cleared.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// matrix_row_sum_sorter
// Loads a matrix row by row, sorts rows by sum in a chain of cells, reads
// the row-sorted matrix back element by element.
// ----------------------------------------------------------------------------
`include "matrix_row_sum_sorter_defines.svh"

module matrix_row_sum_sorter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  mrss_pkg::in_item_t                in_data,
  output logic                              out_valid,
  output mrss_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mrss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrss_pkg::CFG_W-1:0]        cfg_data
);
  import mrss_pkg::*;

  function automatic logic [RCNT_W-1:0] rows_used(logic [CFG_W-1:0] v);
    if (v == '0) return RCNT_W'(1);
    if (int'(v) > MAX_ROWS) return RCNT_W'(MAX_ROWS);
    return RCNT_W'(v);
  endfunction

  function automatic logic [CCNT_W-1:0] cols_used(logic [CFG_W-1:0] v);
    if (v == '0) return CCNT_W'(1);
    if (int'(v) > MAX_COLUMNS) return CCNT_W'(MAX_COLUMNS);
    return CCNT_W'(v);
  endfunction

  logic [CFG_W-1:0]        row_count_r, row_count_nxt;
  logic [CFG_W-1:0]        col_count_r, col_count_nxt;
  logic signed [SUM_W-1:0] run_sum_r, run_sum_nxt;
  logic [RCNT_W-1:0]       load_row_r, load_row_nxt;
  logic [CCNT_W-1:0]       load_col_r, load_col_nxt;
  logic [RCNT_W-1:0]       read_row_r, read_row_nxt;
  logic [CCNT_W-1:0]       read_col_r, read_col_nxt;
  logic                    ready_r, ready_nxt;
  logic                    ins_pend_r, ins_pend_nxt;
  logic                    ins_last_r, ins_last_nxt;
  logic signed [SUM_W-1:0] ins_key_r, ins_key_nxt;
  logic [ROW_W-1:0]        ins_row_r, ins_row_nxt;
  logic                    out_valid_r;
  logic [SRC_ROW_W-1:0]    src_r;
  logic                    lir_r, lim_r;

  logic [RCNT_W-1:0]       rows;
  logic [CCNT_W-1:0]       cols;
  logic                    accept, ld_go, rd_go, cfg_we;
  logic                    end_row, end_mat;
  logic signed [VALUE_WIDTH-1:0] ld_val;
  logic signed [SUM_W-1:0] sum_add;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0]  rd_data;
  chain_ctrl_t             ctrl;

  cell_t cell_q [MAX_ROWS];
  logic  keep   [MAX_ROWS];

  assign rows      = rows_used(row_count_r);
  assign cols      = cols_used(col_count_r);
  assign busy      = ins_pend_r;
  assign cfg_ready = !ins_pend_r;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  assign ld_go = accept && (in_data.opcode == OP_LOAD) && !ready_r &&
                 (load_row_r < rows) && (load_col_r < cols);
  assign rd_go = accept && (in_data.opcode == OP_READ) && ready_r &&
                 (read_row_r < rows) && (read_col_r < cols);

  assign ld_val  = in_data.element_value[VALUE_WIDTH-1:0];
  assign sum_add = run_sum_r + SUM_W'(ld_val);

  assign end_row = (read_col_r == CCNT_W'(cols - CCNT_W'(1)));
  assign end_mat = end_row && (read_row_r == RCNT_W'(rows - RCNT_W'(1)));

  assign wr_addr = ADDR_W'(load_row_r[ROW_W-1:0] * MAX_COLUMNS) + ADDR_W'(load_col_r);
  // The head cell always holds the row being read out.
  assign rd_addr = ADDR_W'(cell_q[0].row * MAX_COLUMNS) + ADDR_W'(read_col_r);

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    run_sum_nxt   = run_sum_r;
    load_row_nxt  = load_row_r;
    load_col_nxt  = load_col_r;
    read_row_nxt  = read_row_r;
    read_col_nxt  = read_col_r;
    ready_nxt     = ready_r;
    ins_pend_nxt  = 1'b0;
    ins_last_nxt  = ins_last_r;
    ins_key_nxt   = ins_key_r;
    ins_row_nxt   = ins_row_r;
    ctrl          = '0;

    if (ins_pend_r) begin
      ctrl.insert = 1'b1;
      if (ins_last_r) begin
        ready_nxt = 1'b1;
      end
    end

    if (ld_go) begin
      if (load_col_r == CCNT_W'(cols - CCNT_W'(1))) begin
        ins_pend_nxt = 1'b1;
        ins_key_nxt  = sum_add;
        ins_row_nxt  = load_row_r[ROW_W-1:0];
        ins_last_nxt = (load_row_r == RCNT_W'(rows - RCNT_W'(1)));
        run_sum_nxt  = '0;
        load_col_nxt = '0;
        load_row_nxt = load_row_r + RCNT_W'(1);
      end else begin
        run_sum_nxt  = sum_add;
        load_col_nxt = load_col_r + CCNT_W'(1);
      end
    end

    if (rd_go) begin
      if (end_mat) begin
        ctrl.clear   = 1'b1;
        run_sum_nxt  = '0;
        load_row_nxt = '0;
        load_col_nxt = '0;
        read_row_nxt = '0;
        read_col_nxt = '0;
        ready_nxt    = 1'b0;
      end else if (end_row) begin
        ctrl.shift   = 1'b1;
        read_col_nxt = '0;
        read_row_nxt = read_row_r + RCNT_W'(1);
      end else begin
        read_col_nxt = read_col_r + CCNT_W'(1);
      end
    end

    // A write to the row or column count register empties the chain and resets the counters.
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ROW_COUNT: begin
          row_count_nxt = cfg_data;
          ctrl.clear    = 1'b1;
        end
        REG_COLUMN_COUNT: begin
          col_count_nxt = cfg_data;
          ctrl.clear    = 1'b1;
        end
        default: ;
      endcase
      if (ctrl.clear) begin
        ctrl.insert  = 1'b0;
        ctrl.shift   = 1'b0;
        run_sum_nxt  = '0;
        load_row_nxt = '0;
        load_col_nxt = '0;
        read_row_nxt = '0;
        read_col_nxt = '0;
        ready_nxt    = 1'b0;
        ins_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_W'(1);
      col_count_r <= CFG_W'(1);
      run_sum_r   <= '0;
      load_row_r  <= '0;
      load_col_r  <= '0;
      read_row_r  <= '0;
      read_col_r  <= '0;
      ready_r     <= 1'b0;
      ins_pend_r  <= 1'b0;
      ins_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      run_sum_r   <= run_sum_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      read_row_r  <= read_row_nxt;
      read_col_r  <= read_col_nxt;
      ready_r     <= ready_nxt;
      ins_pend_r  <= ins_pend_nxt;
      ins_last_r  <= ins_last_nxt;
      out_valid_r <= rd_go;
    end
  end

  always_ff @(posedge clk) begin
    ins_key_r <= ins_key_nxt;
    ins_row_r <= ins_row_nxt;
    if (rd_go) begin
      src_r <= SRC_ROW_W'(cell_q[0].row);
      lir_r <= end_row;
      lim_r <= end_mat;
    end
  end

  // Sorting chain: cell 0 holds the smallest sum.
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    cell_t left_c;
    cell_t right_c;
    logic  left_k;

    if (i == 0) begin : g_head
      assign left_c = '0;
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_c = cell_q[i-1];
      assign left_k = keep[i-1];
    end

    if (i == MAX_ROWS - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_mid
      assign right_c = cell_q[i+1];
    end

    mrss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .key       (ins_key_r),
      .key_row   (ins_row_r),
      .left      (left_c),
      .left_keep (left_k),
      .right     (right_c),
      .q         (cell_q[i]),
      .keep      (keep[i])
    );
  end

  mrss_store u_store (
    .clk     (clk),
    .wr_en   (ld_go),
    .wr_addr (wr_addr),
    .wr_data (ld_val),
    .rd_en   (rd_go),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid               = out_valid_r;
  assign out_data.out_value      = OUT_W'(signed'(rd_data));
  assign out_data.source_row     = src_r;
  assign out_data.last_in_row    = lir_r;
  assign out_data.last_in_matrix = lim_r;

  `MRSS_ASSERT_NEXT(a_read_strobes, clk, rst_n, rd_go, out_valid)
  `MRSS_ASSERT_NEXT(a_no_spurious_out, clk, rst_n, !rd_go, !out_valid)
  `MRSS_ASSERT_NEXT(a_insert_one_cycle, clk, rst_n, busy, !busy)
  `MRSS_ASSERT_SAME(a_ready_head_occ, clk, rst_n, ready_r, cell_q[0].occ)
  `MRSS_ASSERT_SAME(a_head_sorted, clk, rst_n, cell_q[1].occ, cell_q[0].sum <= cell_q[1].sum)

endmodule
